// ===== sv/listener_space_point_transform_core_macros.svh =====
// ---------------------------------------------------------------------------
// Listener transform assertion macros
// Shared shorthand for the concurrent checks of the transform core.
// ---------------------------------------------------------------------------
`ifndef LISTENER_SPACE_POINT_TRANSFORM_CORE_MACROS_SVH
`define LISTENER_SPACE_POINT_TRANSFORM_CORE_MACROS_SVH

// same-cycle implication under reset
`define LSPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define LSPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lspt_pkg.sv =====
// ---------------------------------------------------------------------------
// Listener transform package
// Widths, register codes, the CORDIC arctangent table and helpers.
// ---------------------------------------------------------------------------
package lspt_pkg;

  localparam int POS_WIDTH_DEF    = 32;
  localparam int SINCOS_STEPS_DEF = 16;
  localparam int COEF_W           = 18;
  localparam int ANG_W            = 16;
  localparam int CORDIC_W         = 34;
  localparam int OUT_W            = 32;

  localparam logic signed [COEF_W-1:0]   ONE_Q16      = 18'sd65536;
  localparam logic signed [CORDIC_W-1:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [16:0]         FULL_TURN    = 17'sd23040;
  localparam logic signed [16:0]         HALF_TURN    = 17'sd11520;
  localparam logic signed [16:0]         QUARTER_TURN = 17'sd5760;

  typedef logic signed [COEF_W-1:0] coef_val_t;
  typedef coef_val_t coef_mat_t [9];

  typedef enum logic [2:0] {
    REG_LISTENER_X = 3'd0,
    REG_LISTENER_Y = 3'd1,
    REG_LISTENER_Z = 3'd2,
    REG_ROLL       = 3'd3,
    REG_PITCH      = 3'd4,
    REG_YAW        = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CF_IDLE,
    CF_LOAD,
    CF_ROT,
    CF_ROUND,
    CF_MAT
  } coef_state_t;

  typedef enum logic [2:0] {
    FAC_ZERO, FAC_ONE, FAC_SR, FAC_CR, FAC_SP, FAC_CP, FAC_SY, FAC_CY
  } fac_t;

  typedef struct packed {
    fac_t f1;
    fac_t f2;
    fac_t f3;
    logic neg;
  } term_t;

  typedef struct packed {
    logic signed [13:0] ang;
    logic               neg;
  } fold_t;

  function automatic logic signed [CORDIC_W-1:0] atan_lut(input logic [4:0] k);
    logic signed [CORDIC_W-1:0] v;
    unique case (k)
      5'd0:  v = 34'sd188743680;
      5'd1:  v = 34'sd111421900;
      5'd2:  v = 34'sd58872272;
      5'd3:  v = 34'sd29884485;
      5'd4:  v = 34'sd15000234;
      5'd5:  v = 34'sd7507429;
      5'd6:  v = 34'sd3754631;
      5'd7:  v = 34'sd1877430;
      5'd8:  v = 34'sd938729;
      5'd9:  v = 34'sd469366;
      5'd10: v = 34'sd234683;
      5'd11: v = 34'sd117342;
      5'd12: v = 34'sd58671;
      5'd13: v = 34'sd29335;
      5'd14: v = 34'sd14668;
      5'd15: v = 34'sd7334;
      5'd16: v = 34'sd3667;
      5'd17: v = 34'sd1833;
      5'd18: v = 34'sd917;
      5'd19: v = 34'sd458;
      5'd20: v = 34'sd229;
      5'd21: v = 34'sd115;
      5'd22: v = 34'sd57;
      5'd23: v = 34'sd29;
      default: v = '0;
    endcase
    return v;
  endfunction

  // bring any 16-bit angle into [-90, 90] degrees, noting a half-turn fold
  function automatic fold_t fold_angle(input logic [ANG_W-1:0] raw);
    logic signed [16:0] a;
    fold_t              f;
    a = 17'(signed'(raw));
    if (a >= HALF_TURN) begin
      a = a - FULL_TURN;
    end else if (a < -HALF_TURN) begin
      a = a + FULL_TURN;
    end
    f.neg = 1'b0;
    if (a > QUARTER_TURN) begin
      a = a - HALF_TURN;
      f.neg = 1'b1;
    end else if (a < -QUARTER_TURN) begin
      a = a + HALF_TURN;
      f.neg = 1'b1;
    end
    f.ang = 14'(a);
    return f;
  endfunction

  // two product terms per matrix entry, row-major over (Rx Ry Rz)^T
  function automatic term_t mat_term(input logic [3:0] e, input logic second);
    term_t t;
    t = '{FAC_ZERO, FAC_ZERO, FAC_ZERO, 1'b0};
    unique case (e)
      4'd0: if (!second) t = '{FAC_CP, FAC_CY, FAC_ONE, 1'b0};
      4'd1: t = second ? '{FAC_CR, FAC_SY, FAC_ONE, 1'b0}
                       : '{FAC_SR, FAC_SP, FAC_CY, 1'b0};
      4'd2: t = second ? '{FAC_SR, FAC_SY, FAC_ONE, 1'b0}
                       : '{FAC_CR, FAC_SP, FAC_CY, 1'b1};
      4'd3: if (!second) t = '{FAC_CP, FAC_SY, FAC_ONE, 1'b1};
      4'd4: t = second ? '{FAC_CR, FAC_CY, FAC_ONE, 1'b0}
                       : '{FAC_SR, FAC_SP, FAC_SY, 1'b1};
      4'd5: t = second ? '{FAC_SR, FAC_CY, FAC_ONE, 1'b0}
                       : '{FAC_CR, FAC_SP, FAC_SY, 1'b0};
      4'd6: if (!second) t = '{FAC_SP, FAC_ONE, FAC_ONE, 1'b0};
      4'd7: if (!second) t = '{FAC_SR, FAC_CP, FAC_ONE, 1'b1};
      4'd8: if (!second) t = '{FAC_CR, FAC_CP, FAC_ONE, 1'b0};
      default: t = '{FAC_ZERO, FAC_ZERO, FAC_ZERO, 1'b0};
    endcase
    return t;
  endfunction

  function automatic coef_val_t clamp_unit(input logic signed [22:0] v);
    coef_val_t r;
    if (v > 23'sd65536) begin
      r = ONE_Q16;
    end else if (v < -23'sd65536) begin
      r = -ONE_Q16;
    end else begin
      r = COEF_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== sv/lspt_coef.sv =====
// ---------------------------------------------------------------------------
// Listener transform coefficient unit
// Holds the three angles and rebuilds the nine rotation coefficients
// after each angle write: CORDIC sine/cosine, then a product pipeline.
// ---------------------------------------------------------------------------
module lspt_coef #(
  parameter int SINCOS_STEPS = lspt_pkg::SINCOS_STEPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         ang_we,
  input  logic [1:0]                   ang_sel,
  input  logic [lspt_pkg::ANG_W-1:0]   ang_data,
  output lspt_pkg::coef_mat_t          coef,
  output logic                         busy
);
  import lspt_pkg::*;

  localparam int STEP_W = $clog2(SINCOS_STEPS);
  localparam int PROD1_W = 2 * COEF_W;
  localparam int PROD2_W = PROD1_W + COEF_W;

  coef_state_t state_r, state_nxt;

  logic [ANG_W-1:0]          ang_r  [3];
  logic signed [CORDIC_W-1:0] x_r   [3];
  logic signed [CORDIC_W-1:0] y_r   [3];
  logic signed [CORDIC_W-1:0] z_r   [3];
  logic                       neg_r [3];
  logic [1:0]                 exact_r [3];
  coef_val_t                  sin_r [3];
  coef_val_t                  cos_r [3];
  coef_mat_t                  coef_r;

  logic [STEP_W-1:0] step_r;
  logic [3:0]        cnt_r;
  logic              v1_r, v2_r;
  logic [3:0]        e1_r, e2_r;
  logic signed [PROD1_W-1:0] pa_r, pb_r;
  coef_val_t                 fa_r, fb_r;
  logic signed [PROD2_W-1:0] qa_r, qb_r;

  logic issue;
  term_t ta, tb;

  function automatic coef_val_t pick(input fac_t f, input coef_val_t s [3],
                                     input coef_val_t c [3]);
    coef_val_t v;
    unique case (f)
      FAC_ZERO: v = '0;
      FAC_ONE:  v = ONE_Q16;
      FAC_SR:   v = s[0];
      FAC_CR:   v = c[0];
      FAC_SP:   v = s[1];
      FAC_CP:   v = c[1];
      FAC_SY:   v = s[2];
      FAC_CY:   v = c[2];
      default:  v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CF_IDLE:  if (ang_we) state_nxt = CF_LOAD;
      CF_LOAD:  state_nxt = CF_ROT;
      CF_ROT:   if (step_r == STEP_W'(SINCOS_STEPS - 1)) state_nxt = CF_ROUND;
      CF_ROUND: state_nxt = CF_MAT;
      CF_MAT:   if (cnt_r == 4'd9 && !v1_r && !v2_r) state_nxt = CF_IDLE;
      default:  state_nxt = CF_IDLE;
    endcase
    if (ang_we) state_nxt = CF_LOAD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CF_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy  = (state_r != CF_IDLE) || ang_we;
  assign issue = (state_r == CF_MAT) && (cnt_r < 4'd9);
  assign ta    = mat_term(cnt_r, 1'b0);
  assign tb    = mat_term(cnt_r, 1'b1);

  // angle registers and CORDIC lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        ang_r[i] <= '0;
      end
      step_r <= '0;
    end else begin
      if (ang_we && ang_sel < 2'd3) begin
        ang_r[ang_sel] <= ang_data;
      end
      if (state_r == CF_LOAD) begin
        step_r <= '0;
      end else if (state_r == CF_ROT) begin
        step_r <= step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    fold_t f;
    if (state_r == CF_LOAD) begin
      for (int i = 0; i < 3; i++) begin
        f = fold_angle(ang_r[i]);
        x_r[i]   <= CORDIC_START;
        y_r[i]   <= '0;
        z_r[i]   <= CORDIC_W'(f.ang) <<< 16;
        neg_r[i] <= f.neg;
        // exact codes: 1 zero, 2 plus quarter, 3 minus quarter
        if (f.ang == 14'sd0) begin
          exact_r[i] <= 2'd1;
        end else if (f.ang == 14'sd5760) begin
          exact_r[i] <= 2'd2;
        end else if (f.ang == -14'sd5760) begin
          exact_r[i] <= 2'd3;
        end else begin
          exact_r[i] <= 2'd0;
        end
      end
    end else if (state_r == CF_ROT) begin
      for (int i = 0; i < 3; i++) begin
        if (!z_r[i][CORDIC_W-1]) begin
          x_r[i] <= x_r[i] - (y_r[i] >>> step_r);
          y_r[i] <= y_r[i] + (x_r[i] >>> step_r);
          z_r[i] <= z_r[i] - atan_lut(5'(step_r));
        end else begin
          x_r[i] <= x_r[i] + (y_r[i] >>> step_r);
          y_r[i] <= y_r[i] - (x_r[i] >>> step_r);
          z_r[i] <= z_r[i] + atan_lut(5'(step_r));
        end
      end
    end
  end

  // round lanes to Q1.16, substitute exact values, apply fold sign
  always_ff @(posedge clk) begin
    logic signed [CORDIC_W-1:0] xr, yr;
    coef_val_t s, c;
    if (state_r == CF_ROUND) begin
      for (int i = 0; i < 3; i++) begin
        xr = (x_r[i] + CORDIC_W'(8192)) >>> 14;
        yr = (y_r[i] + CORDIC_W'(8192)) >>> 14;
        unique case (exact_r[i])
          2'd1:    begin s = '0;        c = ONE_Q16; end
          2'd2:    begin s = ONE_Q16;   c = '0;      end
          2'd3:    begin s = -ONE_Q16;  c = '0;      end
          default: begin
            s = clamp_unit(23'(yr));
            c = clamp_unit(23'(xr));
          end
        endcase
        sin_r[i] <= neg_r[i] ? -s : s;
        cos_r[i] <= neg_r[i] ? -c : c;
      end
    end
  end

  // three-stage product pipeline over the nine entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        coef_r[k] <= (k % 4 == 0) ? ONE_Q16 : '0;
      end
    end else begin
      if (state_r == CF_ROUND) begin
        cnt_r <= '0;
      end else if (issue) begin
        cnt_r <= cnt_r + 4'd1;
      end
      v1_r <= issue;
      v2_r <= v1_r;
      if (v2_r) begin
        coef_r[e2_r] <= clamp_unit(23'((qa_r + qb_r + (PROD2_W+1)'(64'sh80000000))
                                       >>> 32));
      end
    end
  end

  always_ff @(posedge clk) begin
    coef_val_t a1, b1;
    a1 = pick(ta.f1, sin_r, cos_r);
    b1 = pick(tb.f1, sin_r, cos_r);
    if (ta.neg) a1 = -a1;
    if (tb.neg) b1 = -b1;
    e1_r <= cnt_r;
    pa_r <= a1 * pick(ta.f2, sin_r, cos_r);
    pb_r <= b1 * pick(tb.f2, sin_r, cos_r);
    fa_r <= pick(ta.f3, sin_r, cos_r);
    fb_r <= pick(tb.f3, sin_r, cos_r);
    e2_r <= e1_r;
    qa_r <= pa_r * fa_r;
    qb_r <= pb_r * fb_r;
  end

  assign coef = coef_r;

endmodule

// ===== sv/listener_space_point_transform_core.sv =====
// ---------------------------------------------------------------------------
// Listener-space point transform core
// Maps object positions into the listener frame, in thousandths of a unit.
// ---------------------------------------------------------------------------
//  channel  | ports                               | role
//  in       | in_valid/in_ready, in_obj_x/y/z     | object position word
//  out      | out_valid/out_ready, out_local_*    | listener-space word
//  cfg      | cfg_wr_en, cfg_index, cfg_wdata     | pose register writes
//
// One word per cycle, while in_ready is high, through five register stages:
// subtract, partial products, row sums, scale by 1000, floor and saturate.
// An angle write rebuilds the coefficients, holding in_ready low from the
// write cycle on, through the CORDIC lanes and the product pipeline.
// Reset loads the identity rotation and a zero listener position.
// A stall holds each full stage; empty stages keep filling.
module listener_space_point_transform_core #(
  parameter int POS_WIDTH    = lspt_pkg::POS_WIDTH_DEF,
  parameter int SINCOS_STEPS = lspt_pkg::SINCOS_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [2:0]                         cfg_index,
  input  logic [POS_WIDTH-1:0]               cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [POS_WIDTH-1:0]        in_obj_x,
  input  logic signed [POS_WIDTH-1:0]        in_obj_y,
  input  logic signed [POS_WIDTH-1:0]        in_obj_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [lspt_pkg::OUT_W-1:0]  out_local_x,
  output logic signed [lspt_pkg::OUT_W-1:0]  out_local_y,
  output logic signed [lspt_pkg::OUT_W-1:0]  out_local_z,
  output logic                               out_clipped
);
  import lspt_pkg::*;
  `include "listener_space_point_transform_core_macros.svh"

  localparam int DW   = POS_WIDTH + 1;
  localparam int HW   = DW - 16;
  localparam int PHW  = HW + COEF_W;
  localparam int SHW  = PHW + 2;
  localparam int MHW  = SHW + 10;
  localparam int PLW  = 17 + COEF_W;
  localparam int SLW  = PLW + 2;
  localparam int MLW  = SLW + 10;
  localparam int LSW  = MLW - 16;
  localparam int TW   = MHW + 1;
  localparam int RW   = TW - 16;
  localparam int SW   = (RW > 33) ? RW : 33;
  localparam logic signed [10:0] THOUSAND = 11'sd1000;
  localparam logic signed [SW-1:0] OUT_MAX = SW'(64'sh7FFFFFFF);
  localparam logic signed [SW-1:0] OUT_MIN = SW'(-64'sh80000000);

  logic signed [POS_WIDTH-1:0] lis_r [3];
  coef_mat_t coef;
  logic      coef_busy;
  logic      ang_we;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  logic signed [DW-1:0]  d_r   [3];
  logic signed [PHW-1:0] ph_r  [9];
  logic signed [PLW-1:0] pl_r  [9];
  logic signed [SHW-1:0] hi_r  [3];
  logic signed [SLW-1:0] lo_r  [3];
  logic signed [MHW-1:0] hm_r  [3];
  logic signed [LSW-1:0] lm_r  [3];
  logic signed [OUT_W-1:0] loc_r [3];
  logic                  clip_r;
  logic                  out_at_bound;

  // ---- configuration ----
  assign ang_we = cfg_wr_en && (cfg_index == REG_ROLL || cfg_index == REG_PITCH ||
                                cfg_index == REG_YAW);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        lis_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_LISTENER_X: lis_r[0] <= cfg_wdata;
        REG_LISTENER_Y: lis_r[1] <= cfg_wdata;
        REG_LISTENER_Z: lis_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lspt_coef #(
    .SINCOS_STEPS (SINCOS_STEPS)
  ) u_coef (
    .clk      (clk),
    .rst_n    (rst_n),
    .ang_we   (ang_we),
    .ang_sel  (2'(cfg_index - REG_ROLL)),
    .ang_data (cfg_wdata[ANG_W-1:0]),
    .coef     (coef),
    .busy     (coef_busy)
  );

  // ---- stage control: a stage advances when empty or when the next moves ----
  assign rdy5     = !v5_r || out_ready;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1 && !coef_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid && in_ready;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // stage 1: offset from listener
  always_ff @(posedge clk) begin
    if (rdy1) begin
      d_r[0] <= DW'(in_obj_x) - DW'(lis_r[0]);
      d_r[1] <= DW'(in_obj_y) - DW'(lis_r[1]);
      d_r[2] <= DW'(in_obj_z) - DW'(lis_r[2]);
    end
  end

  // stage 2: split each offset and form the partial products
  always_ff @(posedge clk) begin
    logic signed [HW-1:0] dh;
    logic signed [16:0]   dl;
    if (rdy2) begin
      for (int j = 0; j < 3; j++) begin
        dh = HW'(d_r[j] >>> 16);
        dl = $signed({1'b0, d_r[j][15:0]});
        for (int i = 0; i < 3; i++) begin
          ph_r[i*3+j] <= coef[i*3+j] * dh;
          pl_r[i*3+j] <= coef[i*3+j] * dl;
        end
      end
    end
  end

  // stage 3: row sums
  always_ff @(posedge clk) begin
    if (rdy3) begin
      for (int i = 0; i < 3; i++) begin
        hi_r[i] <= SHW'(ph_r[i*3]) + SHW'(ph_r[i*3+1]) + SHW'(ph_r[i*3+2]);
        lo_r[i] <= SLW'(pl_r[i*3]) + SLW'(pl_r[i*3+1]) + SLW'(pl_r[i*3+2]);
      end
    end
  end

  // stage 4: scale to thousandths
  always_ff @(posedge clk) begin
    logic signed [MLW-1:0] lm;
    if (rdy4) begin
      for (int i = 0; i < 3; i++) begin
        hm_r[i] <= hi_r[i] * THOUSAND;
        lm      = lo_r[i] * THOUSAND;
        lm_r[i] <= LSW'(lm >>> 16);
      end
    end
  end

  // stage 5: floor, saturate and hold for the consumer
  always_ff @(posedge clk) begin
    logic signed [TW-1:0] t;
    logic signed [SW-1:0] r;
    logic                 clip;
    if (rdy5) begin
      clip = 1'b0;
      for (int i = 0; i < 3; i++) begin
        t = TW'(hm_r[i]) + TW'(lm_r[i]);
        r = SW'(RW'(t >>> 16));
        if (r > OUT_MAX) begin
          loc_r[i] <= OUT_W'(OUT_MAX);
          clip = 1'b1;
        end else if (r < OUT_MIN) begin
          loc_r[i] <= OUT_W'(OUT_MIN);
          clip = 1'b1;
        end else begin
          loc_r[i] <= OUT_W'(r);
        end
      end
      clip_r <= clip;
    end
  end

  assign out_valid   = v5_r;
  assign out_local_x = loc_r[0];
  assign out_local_y = loc_r[1];
  assign out_local_z = loc_r[2];
  assign out_clipped = clip_r;

  // ---- checks ----
  assign out_at_bound = out_local_x == 32'sh7FFFFFFF || out_local_x == -32'sh80000000 ||
                        out_local_y == 32'sh7FFFFFFF || out_local_y == -32'sh80000000 ||
                        out_local_z == 32'sh7FFFFFFF || out_local_z == -32'sh80000000;

  `LSPT_ASSERT_NOW(a_no_accept_busy, in_ready, !coef_busy, "word accepted during coefficient rebuild")
  `LSPT_ASSERT_NEXT(a_angle_starts_rebuild, ang_we, coef_busy, "angle write did not start rebuild")
  `LSPT_ASSERT_NOW(a_clip_at_bound, out_valid && out_clipped, out_at_bound, "clip without saturation")

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Listener transform core testbench
// Streams object positions through the core under a run of listener poses.
// A scoreboard predicts each listener-space word bit for bit and checks the
// words in order, with random stalls on both channels.
// ---------------------------------------------------------------------------
module testbench;
  import lspt_pkg::*;

  localparam int STEPS = SINCOS_STEPS_DEF;
  localparam int SETTLE = 48;

  typedef struct {
    logic signed [31:0] lx;
    logic signed [31:0] ly;
    logic signed [31:0] lz;
    logic               clip;
  } local_word_t;

  class transform_scoreboard;
    local_word_t pending[$];
    int          errors;
    longint      pos[3];
    logic [15:0] ang[3];
    longint      coef[9];
    longint      atan_tab[24] = '{188743680, 111421900, 58872272, 29884485, 15000234,
                                 7507429, 3754631, 1877430, 938729, 469366, 234683,
                                 117342, 58671, 29335, 14668, 7334, 3667, 1833, 917,
                                 458, 229, 115, 57, 29};

    function new();
      errors = 0;
      foreach (pos[k]) pos[k] = 0;
      foreach (ang[k]) ang[k] = '0;
      foreach (coef[k]) coef[k] = (k % 4 == 0) ? 65536 : 0;
    endfunction

    function longint unit_clamp(longint v);
      if (v > 65536) return 65536;
      if (v < -65536) return -65536;
      return v;
    endfunction

    function void sin_cos(logic [15:0] raw, output longint s, output longint c);
      int     a;
      bit     neg;
      longint x, y, z, dx, dy;
      a = int'(signed'(raw));
      neg = 0;
      a = ((a % 23040) + 23040) % 23040;
      if (a >= 11520) a -= 23040;
      // fold beyond a quarter turn, negate both
      if (a > 5760) begin
        a -= 11520;
        neg = 1;
      end else if (a < -5760) begin
        a += 11520;
        neg = 1;
      end
      if (a == 0) begin
        s = 0;
        c = 65536;
      end else if (a == 5760) begin
        s = 65536;
        c = 0;
      end else if (a == -5760) begin
        s = -65536;
        c = 0;
      end else begin
        x = 652032874;
        y = 0;
        z = longint'(a) * 65536;
        for (int i = 0; i < STEPS && i < 24; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (z >= 0) begin
            x -= dx; y += dy; z -= atan_tab[i];
          end else begin
            x += dx; y -= dy; z += atan_tab[i];
          end
        end
        c = unit_clamp((x + 8192) >>> 14);
        s = unit_clamp((y + 8192) >>> 14);
      end
      if (neg) begin
        s = -s;
        c = -c;
      end
    endfunction

    function longint round_coef(longint v);
      return unit_clamp((v + (longint'(1) <<< 31)) >>> 32);
    endfunction

    function void rebuild();
      longint sr, cr, sp, cp, sy, cy;
      sin_cos(ang[0], sr, cr);
      sin_cos(ang[1], sp, cp);
      sin_cos(ang[2], sy, cy);
      coef[0] = round_coef(cp * cy * 65536);
      coef[3] = round_coef(-cp * sy * 65536);
      coef[6] = round_coef(sp * 65536 * 65536);
      coef[1] = round_coef(sr * sp * cy + cr * sy * 65536);
      coef[4] = round_coef(-sr * sp * sy + cr * cy * 65536);
      coef[7] = round_coef(-sr * cp * 65536);
      coef[2] = round_coef(-cr * sp * cy + sr * sy * 65536);
      coef[5] = round_coef(cr * sp * sy + sr * cy * 65536);
      coef[8] = round_coef(cr * cp * 65536);
    endfunction

    function void set_reg(cfg_reg_t idx, logic [31:0] v);
      case (idx)
        REG_LISTENER_X: pos[0] = longint'(signed'(v));
        REG_LISTENER_Y: pos[1] = longint'(signed'(v));
        REG_LISTENER_Z: pos[2] = longint'(signed'(v));
        REG_ROLL: begin
          ang[0] = v[15:0]; rebuild();
        end
        REG_PITCH: begin
          ang[1] = v[15:0]; rebuild();
        end
        REG_YAW: begin
          ang[2] = v[15:0]; rebuild();
        end
        default: ;
      endcase
    endfunction

    function void note(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz);
      longint      d[3], dh[3], dl[3], hi, lo, r;
      logic [31:0] o[3];
      local_word_t w;
      o[0] = ox; o[1] = oy; o[2] = oz;
      w.clip = 0;
      for (int j = 0; j < 3; j++) begin
        d[j] = longint'(signed'(o[j])) - pos[j];
        dh[j] = d[j] >>> 16;
        dl[j] = d[j] - dh[j] * 65536;
      end
      for (int i = 0; i < 3; i++) begin
        hi = 0;
        lo = 0;
        for (int j = 0; j < 3; j++) begin
          hi += coef[i*3+j] * dh[j];
          lo += coef[i*3+j] * dl[j];
        end
        r = (hi * 1000 + ((lo * 1000) >>> 16)) >>> 16;
        if (r > 64'sd2147483647) begin
          r = 64'sd2147483647; w.clip = 1;
        end
        if (r < -64'sd2147483648) begin
          r = -64'sd2147483648; w.clip = 1;
        end
        if (i == 0) w.lx = r[31:0];
        else if (i == 1) w.ly = r[31:0];
        else w.lz = r[31:0];
      end
      pending.push_back(w);
    endfunction

    function void check(local_word_t got);
      local_word_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word x=%0d y=%0d z=%0d clip=%0b", $time,
                 got.lx, got.ly, got.lz, got.clip);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (exp_w.lx !== got.lx || exp_w.ly !== got.ly || exp_w.lz !== got.lz ||
          exp_w.clip !== got.clip) begin
        $display({"%0t: mismatch expected x=%0d y=%0d z=%0d clip=%0b",
                  " actual x=%0d y=%0d z=%0d clip=%0b"},
                 $time, exp_w.lx, exp_w.ly, exp_w.lz, exp_w.clip,
                 got.lx, got.ly, got.lz, got.clip);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid, in_ready;
  logic signed [31:0] in_obj_x, in_obj_y, in_obj_z;
  logic        out_valid, out_ready;
  logic signed [31:0] out_local_x, out_local_y, out_local_z;
  logic        out_clipped;

  transform_scoreboard sb = new();
  int send_idle, recv_idle;

  listener_space_point_transform_core dut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note(in_obj_x, in_obj_y, in_obj_z);
    if (rst_n && out_valid && out_ready)
      sb.check('{out_local_x, out_local_y, out_local_z, out_clipped});
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk) in_valid <= 0;
    end
    @(negedge clk);
    in_valid <= 1;
    in_obj_x <= x;
    in_obj_y <= y;
    in_obj_z <= z;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold off until the pipe has drained
  task automatic drain();
    @(negedge clk) in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    @(negedge clk);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    sb.set_reg(cfg_reg_t'(idx), v);
    @(negedge clk) cfg_wr_en <= 0;
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return 32'(signed'($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  function automatic logic [31:0] pick_angle();
    case ($urandom_range(5))
      0: return 32'(signed'(23040));
      1: return 32'(signed'(-23040));
      2: return 32'(signed'(5760 * $urandom_range(0, 8)) - 23040);
      3: return $urandom;
      default: return {16'($urandom_range(65535)),
                       16'(signed'($urandom_range(0, 46080)) - 23040)};
    endcase
  endfunction

  initial begin
    rst_n = 0;
    cfg_wr_en = 0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 0;
    in_obj_x = '0;
    in_obj_y = '0;
    in_obj_z = '0;
    out_ready = 0;
    send_idle = 20;
    recv_idle = 53;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1;
    repeat (SETTLE) @(negedge clk);

    // identity pose, field extremes
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    send_point(32'h0001_0000, 32'h0000_0001, 32'hffff_0000);
    drain();
    // opposite listener extreme, angles at full turn and quarter turns
    write_reg(REG_LISTENER_X, 32'h7fff_ffff);
    write_reg(REG_LISTENER_Y, 32'h8000_0000);
    write_reg(REG_LISTENER_Z, 32'h0001_8000);
    write_reg(REG_ROLL, 32'(signed'(23040)));
    write_reg(REG_PITCH, 32'(signed'(5760)));
    write_reg(REG_YAW, 32'(signed'(-5760)));
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_point(32'h0, 32'h0, 32'h0);
    drain();
    // beyond a quarter turn, raw pattern extremes, ignored indexes
    write_reg(REG_ROLL, 32'h0000_7fff);
    write_reg(REG_PITCH, 32'hffff_8000);
    write_reg(REG_YAW, 32'(signed'(-23040)));
    write_reg(3'd6, 32'h1234_5678);
    write_reg(3'd7, 32'hffff_ffff);
    for (int k = 0; k < 8; k++) send_point(pick_coord(), pick_coord(), pick_coord());
    drain();
    write_reg(REG_ROLL, 32'(signed'(7000)));
    write_reg(REG_PITCH, 32'(signed'(-300)));
    write_reg(REG_YAW, 32'(signed'(12345)));
    for (int k = 0; k < 8; k++) send_point(pick_coord(), pick_coord(), pick_coord());
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      if (ph < 3) begin
        send_idle = 20; recv_idle = 53;
      end else if (ph < 6) begin
        send_idle = 53; recv_idle = 20;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      for (int r = 0; r < 3; r++) write_reg(3'(r), pick_coord());
      for (int r = 3; r < 6; r++) write_reg(3'(r), pick_angle());
      for (int k = 0; k < 150; k++) begin
        send_point(pick_coord(), pick_coord(), pick_coord());
        // stretch with no send idles inside each phase
        if (k == 60) begin
          send_idle = 0;
        end
      end
      drain();
    end

    @(negedge clk) in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
